>>> hdl/sitoa_pkg.sv
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared types, constants and helpers for the signed integer to ASCII
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sitoa_pkg;

    // default width of the signed input value
    localparam int VALUE_WIDTH_DEFAULT = 32;

    // radix register limits and reset value
    localparam int BASE_WIDTH = 6;
    localparam logic [BASE_WIDTH-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_WIDTH-1:0] BASE_MIN   = 6'd2;
    localparam logic [BASE_WIDTH-1:0] BASE_MAX   = 6'd36;

    // ascii encoding
    localparam int CHAR_WIDTH = 7;
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO     = 7'd48;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS    = 7'd45;
    localparam logic [CHAR_WIDTH-1:0] LETTER_OFFSET = 7'd87;
    localparam logic [BASE_WIDTH-1:0] DECIMAL_LIMIT = 6'd10;

    // converter sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_READ,
        ST_LOAD
    } sitoa_state_t;

    // clamp the radix register to the supported range
    function automatic logic [BASE_WIDTH-1:0] clamp_base(input logic [BASE_WIDTH-1:0] b);
        logic [BASE_WIDTH-1:0] r;
        if (b < BASE_MIN)
            r = BASE_MIN;
        else if (b > BASE_MAX)
            r = BASE_MAX;
        else
            r = b;
        return r;
    endfunction

    // map a digit value to its ascii character
    function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [BASE_WIDTH-1:0] d);
        logic [CHAR_WIDTH-1:0] c;
        if (d >= DECIMAL_LIMIT)
            c = {1'b0, d} + LETTER_OFFSET;
        else
            c = {1'b0, d} + CHAR_ZERO;
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hdl/signed_integer_to_ascii_digits.sv
// ----------------------------------------------------------------------------
// signed_integer_to_ascii_digits
// Converts one signed integer into its ASCII text form, most significant
// character first, with a minus sign for negative values.
// ----------------------------------------------------------------------------
// One value is taken at a time. The magnitude runs through a bit-serial
// restoring divider that produces one quotient bit per cycle; the remainder
// of each digit is pushed onto a small digit stack. The digits are then
// popped out one character at a time: a stack read state, then a load of the
// output register, which waits while the output is stalled. A minus sign, if
// any, is loaded into the output register before the digits.
// The radix register may only be written while no conversion is in flight;
// values below 2 act as 2 and above 36 act as 36.
`default_nettype none

module signed_integer_to_ascii_digits
    import sitoa_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    // radix configuration
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [BASE_WIDTH-1:0]               cfg_data,    // digit_base

    // input value stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_tdata,     // value, zero pad

    // output character stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [7:0]                               m_tdata,     // character, zero pad
    output logic                                     m_tlast
);

    localparam int ADDR_W = $clog2(VALUE_WIDTH);
    localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
    localparam logic [ADDR_W-1:0] BIT_LAST = ADDR_W'(VALUE_WIDTH - 1);

    sitoa_state_t              state_reg, state_next;
    logic [BASE_WIDTH-1:0]     base_reg;
    logic [BASE_WIDTH-1:0]     base_eff;
    logic [VALUE_WIDTH-1:0]    mag_reg, mag_next;
    logic [BASE_WIDTH-1:0]     rem_reg, rem_next;
    logic                      neg_reg, neg_next;
    logic [ADDR_W-1:0]         bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]          digit_count_reg, digit_count_next;
    logic [BASE_WIDTH-1:0]     digit_mem [VALUE_WIDTH];
    logic [BASE_WIDTH-1:0]     rd_data_reg;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      push;
    logic [BASE_WIDTH:0]       trial;
    logic [BASE_WIDTH:0]       trial_diff;
    logic                      qbit;
    logic [BASE_WIDTH-1:0]     rem_step;
    logic [VALUE_WIDTH-1:0]    in_value;
    logic [VALUE_WIDTH-1:0]    in_mag;
    logic                      out_free;
    logic                      out_load;
    logic [CHAR_WIDTH-1:0]     out_char;
    logic                      out_last;
    logic                      m_tvalid_reg;
    logic [CHAR_WIDTH-1:0]     m_char_reg;
    logic                      m_tlast_reg;

    // radix register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= BASE_RESET;
        else if (cfg_valid && cfg_ready)
            base_reg <= cfg_data;
    end

    assign cfg_ready = 1'b1;
    assign base_eff  = clamp_base(base_reg);

    // input magnitude, most negative value maps to 2^(w-1)
    assign in_value = s_tdata[VALUE_WIDTH-1:0];
    assign in_mag   = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;

    // one restoring division step
    assign trial      = {rem_reg, mag_reg[VALUE_WIDTH-1]};
    assign trial_diff = trial - {1'b0, base_eff};
    assign qbit       = (trial >= {1'b0, base_eff});
    assign rem_step   = qbit ? trial_diff[BASE_WIDTH-1:0] : trial[BASE_WIDTH-1:0];

    // output register handshake
    assign out_free = !m_tvalid_reg || m_tready;

    // stack read address is the top digit
    assign rd_addr = ADDR_W'(digit_count_reg - 1'b1);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            digit_count_reg <= '0;
            bit_cnt_reg     <= '0;
            neg_reg         <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            digit_count_reg <= digit_count_next;
            bit_cnt_reg     <= bit_cnt_next;
            neg_reg         <= neg_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
    end

    // next state and datapath control
    always_comb
    begin
        state_next       = state_reg;
        mag_next         = mag_reg;
        rem_next         = rem_reg;
        neg_next         = neg_reg;
        bit_cnt_next     = bit_cnt_reg;
        digit_count_next = digit_count_reg;
        push             = 1'b0;
        out_load         = 1'b0;
        out_char         = CHAR_MINUS;
        out_last         = 1'b0;
        s_tready         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    mag_next         = in_mag;
                    neg_next         = in_value[VALUE_WIDTH-1];
                    rem_next         = '0;
                    bit_cnt_next     = '0;
                    digit_count_next = '0;
                    state_next       = ST_DIVIDE;
                end
            end

            ST_DIVIDE:
            begin
                mag_next     = {mag_reg[VALUE_WIDTH-2:0], qbit};
                rem_next     = rem_step;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_LAST)
                begin
                    // digit done: push remainder, stop once quotient is zero
                    push             = 1'b1;
                    digit_count_next = digit_count_reg + 1'b1;
                    bit_cnt_next     = '0;
                    if (mag_next == '0)
                        state_next = neg_reg ? ST_SIGN : ST_READ;
                    else
                        rem_next = '0;
                end
            end

            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_char   = CHAR_MINUS;
                    out_last   = 1'b0;
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                state_next = ST_LOAD;
            end

            ST_LOAD:
            begin
                if (out_free)
                begin
                    out_load         = 1'b1;
                    out_char         = digit_char(rd_data_reg);
                    out_last         = (digit_count_reg == CNT_W'(1));
                    digit_count_next = digit_count_reg - 1'b1;
                    state_next       = out_last ? ST_IDLE : ST_READ;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // digit stack
    always_ff @(posedge clk)
    begin
        if (push)
            digit_mem[digit_count_reg[ADDR_W-1:0]] <= rem_step;
        rd_data_reg <= digit_mem[rd_addr];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_char_reg  <= out_char;
            m_tlast_reg <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_char_reg};
    assign m_tlast  = m_tlast_reg;

    // checks

    // a new value is only taken with an empty digit stack
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> digit_count_reg == '0)
        else $error("input accepted with digits pending");

    // divider remainder stays below the radix
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIVIDE |-> rem_reg < base_eff)
        else $error("remainder out of range");

    // stack never overflows while dividing
    a_stack_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIVIDE |-> digit_count_reg < CNT_W'(VALUE_WIDTH))
        else $error("digit stack overflow");

    // popping only happens with digits on the stack
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_LOAD) |-> digit_count_reg != '0)
        else $error("pop from empty digit stack");

endmodule

`default_nettype wire

>>> tb/sv/signed_integer_to_ascii_digits_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_integer_to_ascii_digits_tb
// Self-checking bench for the signed integer to ASCII converter. A queue-fed
// driver offers values, a predictor spells each accepted value in the current
// radix, and a monitor checks every output character and its last flag in
// order. The radix register is swept through in-range and saturating settings
// between quiet phases, under changing idle patterns on both stream sides.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_integer_to_ascii_digits_tb;
    import sitoa_pkg::*;

    localparam int VW         = VALUE_WIDTH_DEFAULT;
    localparam int DATA_W     = ((VW + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD  = 600;

    // one expected output character
    typedef struct packed {
        logic [CHAR_WIDTH-1:0] character;
        logic                  last;
    } glyph_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [BASE_WIDTH-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata   = '0;   // value
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;          // character, zero pad
    logic                  m_tlast;

    logic [VW-1:0]         pending_values[$];
    glyph_t                expected_glyphs[$];
    logic [BASE_WIDTH-1:0] radix_copy = BASE_RESET;
    int                    send_idle_pct = 21;
    int                    recv_idle_pct = 70;
    int                    hold_req_seq  = 0;
    int                    hold_seen     = 0;
    int                    hold_left     = 0;
    int                    idle_cycles   = 0;
    int                    errors        = 0;

    signed_integer_to_ascii_digits #(
        .VALUE_WIDTH (VW)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // spell one accepted value in the current radix, most significant first
    task automatic spell_value(input logic [VW-1:0] value);
        logic [VW-1:0]         mag;
        logic [BASE_WIDTH-1:0] digit[VW];
        int unsigned           radix;
        int                    ndig;
        glyph_t                g;
        if (radix_copy < BASE_MIN)
            radix = BASE_MIN;
        else if (radix_copy > BASE_MAX)
            radix = BASE_MAX;
        else
            radix = radix_copy;
        mag  = value[VW-1] ? (~value + 1'b1) : value;
        ndig = 0;
        do
        begin
            digit[ndig] = BASE_WIDTH'(mag % radix);
            ndig++;
            mag = mag / radix;
        end
        while (mag != 0);
        if (value[VW-1])
        begin
            g.character = CHAR_MINUS;
            g.last      = 1'b0;
            expected_glyphs.push_back(g);
        end
        for (int k = ndig - 1; k >= 0; k--)
        begin
            if (digit[k] >= DECIMAL_LIMIT)
                g.character = digit[k] + LETTER_OFFSET;
            else
                g.character = digit[k] + CHAR_ZERO;
            g.last = (k == 0);
            expected_glyphs.push_back(g);
        end
    endtask

    // driver: offer pending values, predict on each accepted transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                spell_value(s_tdata[VW-1:0]);
            if (!s_tvalid || s_tready)
            begin
                if (pending_values.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_values.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: check characters in order, random and long back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_glyphs.size() == 0)
                begin
                    $error("unexpected character 0x%02h last %0b", m_tdata, m_tlast);
                    errors++;
                end
                else
                begin
                    glyph_t g;
                    g = expected_glyphs.pop_front();
                    if (m_tdata !== {1'b0, g.character})
                    begin
                        $error("character: expected 0x%02h actual 0x%02h",
                               {1'b0, g.character}, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== g.last)
                    begin
                        $error("last: expected %0b actual %0b", g.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (hold_req_seq != hold_seen)
            begin
                hold_seen = hold_req_seq;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("signed_integer_to_ascii_digits_tb NOT OK");
            $finish;
        end
    end

    // wait until nothing is offered or outstanding
    task automatic wait_quiet();
        while (pending_values.size() != 0 || s_tvalid || expected_glyphs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write the radix register while the block is idle
    task automatic set_radix(input logic [BASE_WIDTH-1:0] radix);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= radix;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        radix_copy = radix;
    endtask

    // random value: mostly full range, some small and some extreme
    function automatic logic [VW-1:0] random_value();
        logic [VW-1:0] v;
        int            pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
        begin
            v = $urandom_range(0, 40);
            if ($urandom_range(0, 1))
                v = ~v + 1'b1;
        end
        else if (pick == 3)
        begin
            case ($urandom_range(0, 3))
                0: v = {1'b1, {(VW-1){1'b0}}};
                1: v = {1'b0, {(VW-1){1'b1}}};
                2: v = '1;
                default: v = '0;
            endcase
        end
        else
            v = $urandom;
        return v;
    endfunction

    // stimulus sequence
    initial
    begin
        logic [BASE_WIDTH-1:0] radix;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset radix ten: zero, signs, extremes, alternating bits
        pending_values.push_back(32'd0);
        pending_values.push_back(32'd1);
        pending_values.push_back(32'hFFFF_FFFF);
        pending_values.push_back(32'd9);
        pending_values.push_back(-32'sd10);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'h5555_5555);
        pending_values.push_back(32'hAAAA_AAAA);
        pending_values.push_back(32'd1000000000);

        // radix below range saturates to two, longest output
        set_radix(6'd0);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'd0);
        set_radix(6'd1);
        pending_values.push_back(32'hFFFF_FFFE);
        set_radix(BASE_MIN);
        pending_values.push_back(32'd5);

        // highest radix and above range saturating to it, then radix sixteen
        set_radix(BASE_MAX);
        pending_values.push_back(32'd35);
        pending_values.push_back(-32'sd36);
        pending_values.push_back(32'h8000_0000);
        set_radix(6'd63);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'd1295);
        set_radix(6'd37);
        pending_values.push_back(32'hFFFF_FFFF);
        set_radix(6'd16);
        pending_values.push_back(32'hDEAD_BEEF);
        pending_values.push_back(32'h0123_4567);

        // random, sender idles a little, receiver a lot, one long hold-off
        set_radix(BASE_RESET);
        send_idle_pct = 21;
        recv_idle_pct = 70;
        repeat (45) pending_values.push_back(random_value());
        hold_req_seq++;

        // random, the other way round
        set_radix(6'd16);
        send_idle_pct = 70;
        recv_idle_pct = 21;
        repeat (45) pending_values.push_back(random_value());

        // random radix per chunk, no idling
        for (int chunk = 0; chunk < 5; chunk++)
        begin
            if ($urandom_range(0, 4) == 0)
                radix = BASE_WIDTH'($urandom_range(0, 63));
            else
                radix = BASE_WIDTH'($urandom_range(BASE_MIN, BASE_MAX));
            set_radix(radix);
            send_idle_pct = 0;
            recv_idle_pct = 0;
            repeat (10) pending_values.push_back(random_value());
        end

        // drain and let the block settle
        wait_quiet();
        repeat (50) @(posedge clk);
        if (errors == 0 && expected_glyphs.size() == 0)
            $display("signed_integer_to_ascii_digits_tb OK");
        else
            $display("signed_integer_to_ascii_digits_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
